// File: src/kbts_pkg.sv
// Shared types and constants for the transparency layer store.
`timescale 1ns / 1ps
package kbts_pkg;

  localparam int unsigned COLOR_W = 13;
  localparam int unsigned DEPTH_W = 24;
  localparam int unsigned ACC_W   = 16;
  localparam int unsigned PROD_W  = 26;
  localparam int unsigned FRAC_W  = 12;

  localparam logic [COLOR_W-1:0] ONE_Q12   = 13'd4096;
  localparam logic [PROD_W-1:0]  ROUND_Q12 = 26'd2048;

  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  typedef struct packed {
    depth_t depth;
    color_t red;
    color_t green;
    color_t blue;
    color_t alpha;
  } layer_t;

endpackage

// File: src/kbts_ram.sv
// Single-port-write, registered-read synchronous memory.
`timescale 1ns / 1ps
module kbts_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/kbuffer_transparency_store_core.sv
// Top level: per-pixel fragment store with sequencer, insertion sort and blend datapath.
// Push: writes a free slot while the list has room, else a farthest-slot scan picks the
// slot to replace. Resolve: loads and sorts the n layers, blends the b in front, then the
// destination; none is blended when none is in front, none loaded when out of region or
// empty. A stalled result beat holds the sequencer until taken. One item is worked at a
// time. After reset the count memory is swept to zero, one pixel a cycle, with input stalled.
`timescale 1ns / 1ps
module kbuffer_transparency_store_core #(
  parameter int unsigned LAYERS        = 4,
  parameter int unsigned REGION_WIDTH  = 64,
  parameter int unsigned REGION_HEIGHT = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    operation_i,
  input  logic [5:0]              pixel_x_i,
  input  logic [5:0]              pixel_y_i,
  input  kbts_pkg::color_t        frag_red_i,
  input  kbts_pkg::color_t        frag_green_i,
  input  kbts_pkg::color_t        frag_blue_i,
  input  kbts_pkg::color_t        frag_alpha_i,
  input  kbts_pkg::depth_t        frag_depth_i,
  input  kbts_pkg::color_t        dest_red_i,
  input  kbts_pkg::color_t        dest_green_i,
  input  kbts_pkg::color_t        dest_blue_i,
  input  kbts_pkg::depth_t        dest_depth_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    color_written_o,
  output kbts_pkg::color_t        out_red_o,
  output kbts_pkg::color_t        out_green_o,
  output kbts_pkg::color_t        out_blue_o,
  output logic                    depth_written_o,
  output kbts_pkg::depth_t        out_depth_o
);
  import kbts_pkg::*;

  localparam int unsigned PIXELS = REGION_WIDTH * REGION_HEIGHT;
  localparam int unsigned PIX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned SLOT_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int unsigned CNT_W  = $clog2(LAYERS + 1);
  localparam int unsigned LAY_W  = $bits(layer_t);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_COUNT, S_SCAN, S_PUT, S_LOAD,
    S_MUL, S_ADD, S_DMUL, S_DADD, S_OUT
  } state_e;

  state_e            state_q;
  logic              ph_q;
  logic [PIX_W-1:0]  clr_q;
  logic              cfg_q;
  logic              op_q;
  logic              inr_q;
  logic [PIX_W-1:0]  pix_q;
  layer_t            frag_q;
  color_t            dest_q [3];
  depth_t            dz_q;
  logic [CNT_W-1:0]  n_q;
  logic [CNT_W-1:0]  idx_q;
  logic [CNT_W-1:0]  len_q;
  depth_t            far_q;
  logic [SLOT_W-1:0] slot_q;
  layer_t            sl_q [LAYERS];
  logic [ACC_W-1:0]  acc_q [4];
  logic [PROD_W-1:0] prod_q [4];
  logic              cw_q;

  logic              out_valid_q;
  logic              color_written_q;
  color_t            out_red_q;
  color_t            out_green_q;
  color_t            out_blue_q;
  logic              depth_written_q;
  depth_t            out_depth_q;

  logic [PIX_W-1:0]  pix_in;
  logic              inr_in;
  logic [CNT_W-1:0]  cnt_rd;
  logic [CNT_W-1:0]  n_cl;
  logic              cnt_we;
  logic [PIX_W-1:0]  cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [LAY_W-1:0]  lay_rd_raw;
  layer_t            lay_rd;
  layer_t            ins_d [LAYERS];
  logic              gt [LAYERS];
  layer_t            cur;
  color_t            cur_c [4];
  color_t            w_c;
  logic              blend_go;
  logic [ACC_W-1:0]  scaled [4];
  logic [ACC_W-1:0]  summed [4];

  assign pix_in = PIX_W'(32'(pixel_y_i) * REGION_WIDTH + 32'(pixel_x_i));
  assign inr_in = (32'(pixel_x_i) < REGION_WIDTH) && (32'(pixel_y_i) < REGION_HEIGHT);
  assign in_stall_o = (state_q != S_IDLE);

  assign n_cl = (cnt_rd > CNT_W'(LAYERS)) ? CNT_W'(LAYERS) : cnt_rd;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = pix_q;
    cnt_wdata = '0;
    if (state_q == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
    end else if (state_q == S_COUNT && inr_q) begin
      if (op_q == OP_RESOLVE) begin
        cnt_we = 1'b1;
      end else if (n_cl < CNT_W'(LAYERS)) begin
        cnt_we    = 1'b1;
        cnt_wdata = n_cl + CNT_W'(1);
      end
    end
  end

  kbts_ram #(.DATA_W(CNT_W), .ADDR_W(PIX_W)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (pix_in),
    .rdata_o (cnt_rd)
  );

  kbts_ram #(.DATA_W(LAY_W), .ADDR_W(PIX_W + SLOT_W)) u_layer_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_PUT),
    .waddr_i ({pix_q, slot_q}),
    .wdata_i (frag_q),
    .raddr_i ({pix_q, idx_q[SLOT_W-1:0]}),
    .rdata_o (lay_rd_raw)
  );

  assign lay_rd = layer_t'(lay_rd_raw);

  // stable insertion: new layer goes after all layers of equal or smaller depth
  always_comb begin
    for (int i = 0; i < LAYERS; i++) begin
      gt[i] = (CNT_W'(i) < len_q) && (sl_q[i].depth > lay_rd.depth);
    end
    for (int i = 0; i < LAYERS; i++) begin
      ins_d[i] = sl_q[i];
      if (gt[i]) begin
        if (i == 0) begin
          ins_d[i] = lay_rd;
        end else if (gt[i-1]) begin
          ins_d[i] = sl_q[i-1];
        end else begin
          ins_d[i] = lay_rd;
        end
      end else if (CNT_W'(i) == len_q) begin
        if (i == 0) begin
          ins_d[i] = lay_rd;
        end else if (gt[i-1]) begin
          ins_d[i] = sl_q[i-1];
        end else begin
          ins_d[i] = lay_rd;
        end
      end
    end
  end

  always_comb begin
    cur      = sl_q[idx_q[SLOT_W-1:0]];
    cur_c[0] = cur.red;
    cur_c[1] = cur.green;
    cur_c[2] = cur.blue;
    cur_c[3] = cur.alpha;
    blend_go = (idx_q < len_q) && (cur.depth < dz_q);
    w_c      = (acc_q[3] >= ACC_W'(ONE_Q12)) ? '0 : (ONE_Q12 - acc_q[3][COLOR_W-1:0]);
    for (int k = 0; k < 4; k++) begin
      scaled[k] = ACC_W'((prod_q[k] + ROUND_Q12) >> FRAC_W);
      summed[k] = acc_q[k] + scaled[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_CLEAR;
      ph_q            <= 1'b0;
      clr_q           <= '0;
      cfg_q           <= 1'b0;
      op_q            <= OP_PUSH;
      inr_q           <= 1'b0;
      pix_q           <= '0;
      frag_q          <= '0;
      dz_q            <= '0;
      n_q             <= '0;
      idx_q           <= '0;
      len_q           <= '0;
      far_q           <= '0;
      slot_q          <= '0;
      cw_q            <= 1'b0;
      out_valid_q     <= 1'b0;
      color_written_q <= 1'b0;
      out_red_q       <= '0;
      out_green_q     <= '0;
      out_blue_q      <= '0;
      depth_written_q <= 1'b0;
      out_depth_q     <= '0;
      for (int k = 0; k < 3; k++) begin
        dest_q[k] <= '0;
      end
      for (int k = 0; k < 4; k++) begin
        acc_q[k]  <= '0;
        prod_q[k] <= '0;
      end
      for (int i = 0; i < LAYERS; i++) begin
        sl_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + PIX_W'(1);
          if (clr_q == PIX_W'(PIXELS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q         <= operation_i;
            inr_q        <= inr_in;
            pix_q        <= pix_in;
            frag_q.depth <= frag_depth_i;
            frag_q.red   <= frag_red_i;
            frag_q.green <= frag_green_i;
            frag_q.blue  <= frag_blue_i;
            frag_q.alpha <= frag_alpha_i;
            dest_q[0]    <= dest_red_i;
            dest_q[1]    <= dest_green_i;
            dest_q[2]    <= dest_blue_i;
            dz_q         <= dest_depth_i;
            state_q      <= S_COUNT;
          end
        end
        S_COUNT: begin
          idx_q <= '0;
          len_q <= '0;
          ph_q  <= 1'b0;
          n_q   <= n_cl;
          far_q <= '0;
          priority if (op_q == OP_PUSH) begin
            if (!inr_q) begin
              state_q <= S_IDLE;
            end else if (n_cl < CNT_W'(LAYERS)) begin
              slot_q  <= n_cl[SLOT_W-1:0];
              state_q <= S_PUT;
            end else begin
              slot_q  <= '0;
              state_q <= S_SCAN;
            end
          end else if (!inr_q || n_cl == '0) begin
            cw_q    <= 1'b0;
            for (int k = 0; k < 4; k++) begin
              acc_q[k] <= '0;
            end
            state_q <= S_OUT;
          end else begin
            state_q <= S_LOAD;
          end
        end
        S_SCAN: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (lay_rd.depth > far_q) begin
              far_q  <= lay_rd.depth;
              slot_q <= idx_q[SLOT_W-1:0];
            end
            if (idx_q == CNT_W'(LAYERS - 1)) begin
              state_q <= S_PUT;
            end else begin
              idx_q <= idx_q + CNT_W'(1);
            end
          end
        end
        S_PUT: begin
          state_q <= S_IDLE;
        end
        S_LOAD: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            for (int i = 0; i < LAYERS; i++) begin
              sl_q[i] <= ins_d[i];
            end
            len_q <= len_q + CNT_W'(1);
            if (idx_q + CNT_W'(1) == n_q) begin
              idx_q <= '0;
              for (int k = 0; k < 4; k++) begin
                acc_q[k] <= '0;
              end
              state_q <= S_MUL;
            end else begin
              idx_q <= idx_q + CNT_W'(1);
            end
          end
        end
        S_MUL: begin
          priority if (blend_go) begin
            for (int k = 0; k < 4; k++) begin
              prod_q[k] <= PROD_W'(w_c) * PROD_W'(cur_c[k]);
            end
            state_q <= S_ADD;
          end else if (idx_q == '0) begin
            cw_q <= 1'b0;
            for (int k = 0; k < 4; k++) begin
              acc_q[k] <= '0;
            end
            state_q <= S_OUT;
          end else begin
            state_q <= S_DMUL;
          end
        end
        S_ADD: begin
          for (int k = 0; k < 4; k++) begin
            acc_q[k] <= summed[k];
          end
          idx_q   <= idx_q + CNT_W'(1);
          state_q <= S_MUL;
        end
        S_DMUL: begin
          for (int k = 0; k < 3; k++) begin
            prod_q[k] <= PROD_W'(w_c) * PROD_W'(dest_q[k]);
          end
          prod_q[3] <= '0;
          state_q   <= S_DADD;
        end
        S_DADD: begin
          for (int k = 0; k < 3; k++) begin
            acc_q[k] <= (summed[k] > ACC_W'(ONE_Q12)) ? ACC_W'(ONE_Q12) : summed[k];
          end
          cw_q    <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q     <= 1'b1;
            color_written_q <= cw_q;
            out_red_q       <= acc_q[0][COLOR_W-1:0];
            out_green_q     <= acc_q[1][COLOR_W-1:0];
            out_blue_q      <= acc_q[2][COLOR_W-1:0];
            depth_written_q <= cw_q && cfg_q;
            out_depth_q     <= (cw_q && cfg_q) ? sl_q[0].depth : '0;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign color_written_o = color_written_q;
  assign out_red_o       = out_red_q;
  assign out_green_o     = out_green_q;
  assign out_blue_o      = out_blue_q;
  assign depth_written_o = depth_written_q;
  assign out_depth_o     = out_depth_q;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the transparency layer store, with its own blend predictor.
`timescale 1ns / 1ps
module tb_top;
  import kbts_pkg::*;

  typedef struct packed {
    logic   color_written;
    color_t red;
    color_t green;
    color_t blue;
    logic   depth_written;
    depth_t depth;
  } resolve_beat_t;

  class blend_scoreboard;
    bit          depth_enable;
    int unsigned count_of[4096];
    depth_t      slot_depth[4096][4];
    color_t      slot_color[4096][4][4];
    resolve_beat_t pending[$];
    int          mismatches;

    function automatic int unsigned scale(int unsigned w, int unsigned c);
      return (w * c + 2048) >> 12;
    endfunction

    function void note_beat(logic op, logic [5:0] px, logic [5:0] py,
                            color_t fr, color_t fg, color_t fb, color_t fa, depth_t fd,
                            color_t dr, color_t dg, color_t db, depth_t dd);
      int unsigned pix, n, slot, w, t;
      int unsigned ord[4];
      int unsigned acc[4];
      color_t dst[3];
      depth_t far_z, nearest;
      resolve_beat_t r;
      bit swapped;
      pix = py * 64 + px;
      n = count_of[pix];
      if (op == OP_PUSH) begin
        if (n >= 4) begin
          far_z = '0;
          slot = 0;
          for (int i = 0; i < 4; i++)
            if (slot_depth[pix][i] > far_z) begin
              far_z = slot_depth[pix][i];
              slot = i;
            end
        end else begin
          slot = n;
          count_of[pix] = n + 1;
        end
        slot_color[pix][slot][0] = fr;
        slot_color[pix][slot][1] = fg;
        slot_color[pix][slot][2] = fb;
        slot_color[pix][slot][3] = fa;
        slot_depth[pix][slot] = fd;
        return;
      end
      r = '0;
      count_of[pix] = 0;
      if (n != 0) begin
        for (int i = 0; i < 4; i++) ord[i] = i;
        swapped = 1;
        while (swapped) begin
          swapped = 0;
          for (int i = 1; i < n; i++)
            if (slot_depth[pix][ord[i-1]] > slot_depth[pix][ord[i]]) begin
              t = ord[i]; ord[i] = ord[i-1]; ord[i-1] = t;
              swapped = 1;
            end
        end
        nearest = slot_depth[pix][ord[0]];
        if (nearest < dd) begin
          acc = '{0, 0, 0, 0};
          for (int i = 0; i < n; i++)
            if (slot_depth[pix][ord[i]] < dd) begin
              w = acc[3] >= 4096 ? 0 : 4096 - acc[3];
              for (int k = 0; k < 4; k++) acc[k] += scale(w, slot_color[pix][ord[i]][k]);
            end
          w = acc[3] >= 4096 ? 0 : 4096 - acc[3];
          dst = '{dr, dg, db};
          for (int k = 0; k < 3; k++) begin
            acc[k] += scale(w, dst[k]);
            if (acc[k] > 4096) acc[k] = 4096;
          end
          r.color_written = 1;
          r.red = color_t'(acc[0]);
          r.green = color_t'(acc[1]);
          r.blue = color_t'(acc[2]);
          if (depth_enable) begin
            r.depth_written = 1;
            r.depth = nearest;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_beat(resolve_beat_t got);
      resolve_beat_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected resolve beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0, cfg_wdata_i = 0;
  logic in_valid_i = 0, in_stall_o;
  logic operation_i = 0;
  logic [5:0] pixel_x_i = 0, pixel_y_i = 0;
  color_t frag_red_i = 0, frag_green_i = 0, frag_blue_i = 0, frag_alpha_i = 0;
  depth_t frag_depth_i = 0, dest_depth_i = 0;
  color_t dest_red_i = 0, dest_green_i = 0, dest_blue_i = 0;
  logic out_valid_o, out_stall_i = 0;
  logic color_written_o, depth_written_o;
  color_t out_red_o, out_green_o, out_blue_o;
  depth_t out_depth_o;

  blend_scoreboard sb = new();
  bit calm_stretch = 0;
  int idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  kbuffer_transparency_store_core u_dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_beat('{color_written_o, out_red_o, out_green_o, out_blue_o,
                      depth_written_o, out_depth_o});
    out_stall_i <= !calm_stretch && ($urandom_range(99) < 18);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic color_t rand_color();
    case ($urandom_range(5))
      0: return 0;
      1: return 4096;
      2: return 13'h1fff;
      default: return color_t'($urandom_range(4096));
    endcase
  endfunction

  function automatic depth_t rand_depth();
    case ($urandom_range(5))
      0: return 0;
      1: return 24'hffffff;
      2: return depth_t'($urandom_range(7));
      default: return depth_t'($urandom);
    endcase
  endfunction

  task automatic send_beat(logic op, logic [5:0] px, logic [5:0] py,
                           color_t fr, color_t fg, color_t fb, color_t fa, depth_t fd,
                           color_t dr, color_t dg, color_t db, depth_t dd);
    while (!calm_stretch && $urandom_range(99) < 18) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    operation_i <= op;
    pixel_x_i <= px;
    pixel_y_i <= py;
    frag_red_i <= fr; frag_green_i <= fg; frag_blue_i <= fb; frag_alpha_i <= fa;
    frag_depth_i <= fd;
    dest_red_i <= dr; dest_green_i <= dg; dest_blue_i <= db;
    dest_depth_i <= dd;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(op, px, py, fr, fg, fb, fa, fd, dr, dg, db, dd);
  endtask

  task automatic push_rand(logic [5:0] px, logic [5:0] py);
    send_beat(OP_PUSH, px, py, rand_color(), rand_color(), rand_color(), rand_color(),
              rand_depth(), color_t'($urandom), color_t'($urandom), color_t'($urandom),
              depth_t'($urandom));
  endtask

  task automatic resolve_rand(logic [5:0] px, logic [5:0] py);
    send_beat(OP_RESOLVE, px, py, color_t'($urandom), color_t'($urandom), color_t'($urandom),
              color_t'($urandom), depth_t'($urandom),
              rand_color(), rand_color(), rand_color(), rand_depth());
  endtask

  task automatic drain_and_set(bit value);
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.depth_enable = value;
  endtask

  initial begin
    int n;
    logic [5:0] px, py;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    drain_and_set(1);
    calm_stretch = 1;
    // directed: empty list, extremes, overflow replacement, all-zero depths, dest in front
    resolve_rand(0, 0);
    send_beat(OP_PUSH, 63, 63, 4096, 0, 13'h1fff, 4096, 24'hffffff, 0, 0, 0, 0);
    send_beat(OP_PUSH, 63, 63, 0, 4096, 0, 2048, 0, 0, 0, 0, 0);
    send_beat(OP_RESOLVE, 63, 63, 0, 0, 0, 0, 0, 4096, 4096, 4096, 24'hffffff);
    for (int i = 0; i < 6; i++)
      send_beat(OP_PUSH, 1, 2, color_t'(1000 * i), 300, 4096, 1500, depth_t'(i * 5),
                0, 0, 0, 0);
    send_beat(OP_RESOLVE, 1, 2, 0, 0, 0, 0, 0, 13'h1fff, 0, 2000, 12);
    for (int i = 0; i < 5; i++)
      send_beat(OP_PUSH, 3, 3, 4096, 4096, 4096, 13'h1fff, 0, 0, 0, 0, 0);
    send_beat(OP_RESOLVE, 3, 3, 0, 0, 0, 0, 0, 100, 100, 100, 1);
    send_beat(OP_PUSH, 4, 4, 500, 500, 500, 500, 100, 0, 0, 0, 0);
    send_beat(OP_RESOLVE, 4, 4, 0, 0, 0, 0, 0, 9, 9, 9, 100);
    resolve_rand(4, 4);
    drain_and_set(0);
    send_beat(OP_PUSH, 5, 5, 700, 800, 900, 1000, 50, 0, 0, 0, 0);
    send_beat(OP_RESOLVE, 5, 5, 0, 0, 0, 0, 0, 4096, 0, 4096, 24'hffffff);
    calm_stretch = 0;
    n = 0;
    while (n < 620) begin
      if (n == 300) drain_and_set(1);
      if (n == 450) drain_and_set(0);
      if (n == 500) drain_and_set(1);
      calm_stretch = (n >= 150 && n < 230);
      px = $urandom_range(3) == 0 ? 6'($urandom) : 6'($urandom_range(7));
      py = $urandom_range(3) == 0 ? 6'($urandom) : 6'($urandom_range(7));
      for (int k = $urandom_range(6); k > 0; k--) begin
        push_rand(px, py);
        n++;
      end
      resolve_rand(px, py);
      n++;
    end
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// File: kbuffer_transparency_store_core.f
src/kbts_pkg.sv
src/kbts_ram.sv
src/kbuffer_transparency_store_core.sv
sim/tb_top.sv
